// ===== rtl/keyboard_matrix_port_unit_defines.svh =====
// ----------------------------------------------------------------------------
// keyboard_matrix_port_unit_defines.svh
// Assertion macros shared by the keyboard matrix port RTL.
// ----------------------------------------------------------------------------
`ifndef KEYBOARD_MATRIX_PORT_UNIT_DEFINES_SVH
`define KEYBOARD_MATRIX_PORT_UNIT_DEFINES_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define KMP_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("keyboard matrix port: same-cycle check failed");

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define KMP_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("keyboard matrix port: next-cycle check failed");

`endif

// ===== rtl/kmp_pkg.sv =====
// ----------------------------------------------------------------------------
// kmp_pkg
// Types and constants for the keyboard matrix port.
// ----------------------------------------------------------------------------
package kmp_pkg;

  localparam int unsigned KM_ROWS   = 8;
  localparam int unsigned KM_COLS   = 5;
  localparam int unsigned ROW_W     = 3;
  localparam int unsigned COL_W     = 3;
  localparam int unsigned CODE_W    = 31;
  localparam int unsigned ADDR_W    = 16;
  localparam int unsigned DATA_W    = 8;

  localparam logic [DATA_W-1:0] BUS_IDLE = 8'hFF;

  // Modifier host codes; shift and control each have a left and a right code.
  localparam logic [CODE_W-1:0] KEY_LSHIFT = 31'h400000e1;
  localparam logic [CODE_W-1:0] KEY_RSHIFT = 31'h400000e5;
  localparam logic [CODE_W-1:0] KEY_LCTRL  = 31'h400000e0;
  localparam logic [CODE_W-1:0] KEY_RCTRL  = 31'h400000e4;

  typedef enum logic [1:0] {
    MODE_PRESS   = 2'd0,
    MODE_RELEASE = 2'd1,
    MODE_READ    = 2'd2,
    MODE_IGNORE  = 2'd3
  } kmp_mode_t;

  // One matrix bit update.
  typedef struct packed {
    logic             en;
    logic             set;
    logic [ROW_W-1:0] row;
    logic [COL_W-1:0] col;
  } kmp_upd_t;

endpackage

// ===== rtl/kmp_key_decode.sv =====
// ----------------------------------------------------------------------------
// kmp_key_decode
// Maps a host key code of a press/release event to a matrix bit update.
// ----------------------------------------------------------------------------
module kmp_key_decode
  import kmp_pkg::*;
(
  input  kmp_mode_t         mode,
  input  logic [CODE_W-1:0] host_code,
  output kmp_upd_t          upd
);

  logic             hit;
  logic [ROW_W-1:0] row;
  logic [COL_W-1:0] col;

  always_comb begin
    hit = 1'b1;
    row = '0;
    col = '0;
    case (host_code)
      KEY_LSHIFT, KEY_RSHIFT: begin row = 3'd0; col = 3'd0; end
      31'h7a: begin row = 3'd0; col = 3'd1; end  // z
      31'h78: begin row = 3'd0; col = 3'd2; end  // x
      31'h63: begin row = 3'd0; col = 3'd3; end  // c
      31'h76: begin row = 3'd0; col = 3'd4; end  // v
      31'h61: begin row = 3'd1; col = 3'd0; end  // a
      31'h73: begin row = 3'd1; col = 3'd1; end  // s
      31'h64: begin row = 3'd1; col = 3'd2; end  // d
      31'h66: begin row = 3'd1; col = 3'd3; end  // f
      31'h67: begin row = 3'd1; col = 3'd4; end  // g
      31'h71: begin row = 3'd2; col = 3'd0; end  // q
      31'h77: begin row = 3'd2; col = 3'd1; end  // w
      31'h65: begin row = 3'd2; col = 3'd2; end  // e
      31'h72: begin row = 3'd2; col = 3'd3; end  // r
      31'h74: begin row = 3'd2; col = 3'd4; end  // t
      31'h31: begin row = 3'd3; col = 3'd0; end  // 1
      31'h32: begin row = 3'd3; col = 3'd1; end  // 2
      31'h33: begin row = 3'd3; col = 3'd2; end  // 3
      31'h34: begin row = 3'd3; col = 3'd3; end  // 4
      31'h35: begin row = 3'd3; col = 3'd4; end  // 5
      31'h30: begin row = 3'd4; col = 3'd0; end  // 0
      31'h39: begin row = 3'd4; col = 3'd1; end  // 9
      31'h38: begin row = 3'd4; col = 3'd2; end  // 8
      31'h37: begin row = 3'd4; col = 3'd3; end  // 7
      31'h36: begin row = 3'd4; col = 3'd4; end  // 6
      31'h70: begin row = 3'd5; col = 3'd0; end  // p
      31'h6f: begin row = 3'd5; col = 3'd1; end  // o
      31'h69: begin row = 3'd5; col = 3'd2; end  // i
      31'h75: begin row = 3'd5; col = 3'd3; end  // u
      31'h79: begin row = 3'd5; col = 3'd4; end  // y
      31'h0d: begin row = 3'd6; col = 3'd0; end  // carriage return
      31'h6c: begin row = 3'd6; col = 3'd1; end  // l
      31'h6b: begin row = 3'd6; col = 3'd2; end  // k
      31'h6a: begin row = 3'd6; col = 3'd3; end  // j
      31'h68: begin row = 3'd6; col = 3'd4; end  // h
      31'h20: begin row = 3'd7; col = 3'd0; end  // space
      KEY_LCTRL, KEY_RCTRL: begin row = 3'd7; col = 3'd1; end
      31'h6d: begin row = 3'd7; col = 3'd2; end  // m
      31'h6e: begin row = 3'd7; col = 3'd3; end  // n
      31'h62: begin row = 3'd7; col = 3'd4; end  // b
      default: hit = 1'b0;
    endcase
  end

  always_comb begin
    upd.en  = hit && (mode == MODE_PRESS || mode == MODE_RELEASE);
    upd.set = (mode == MODE_PRESS);
    upd.row = row;
    upd.col = col;
  end

endmodule

// ===== rtl/kmp_matrix.sv =====
// ----------------------------------------------------------------------------
// kmp_matrix
// 8x5 key state flops with single-bit update and row-select read.
// ----------------------------------------------------------------------------
module kmp_matrix
  import kmp_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  kmp_upd_t          upd,
  input  logic [KM_ROWS-1:0] row_sel_n,
  output logic [DATA_W-1:0] rd_data
);

  logic [KM_COLS-1:0] rows_r   [KM_ROWS];
  logic [KM_COLS-1:0] rows_nxt [KM_ROWS];

  always_comb begin
    for (int r = 0; r < KM_ROWS; r++) begin
      rows_nxt[r] = rows_r[r];
    end
    if (upd.en) begin
      rows_nxt[upd.row][upd.col] = upd.set;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int r = 0; r < KM_ROWS; r++) begin
        rows_r[r] <= '0;
      end
    end else begin
      for (int r = 0; r < KM_ROWS; r++) begin
        rows_r[r] <= rows_nxt[r];
      end
    end
  end

  // Held keys read low; unused top bits stay high.
  always_comb begin
    rd_data = BUS_IDLE;
    for (int r = 0; r < KM_ROWS; r++) begin
      if (!row_sel_n[r]) begin
        rd_data = rd_data & ~{{(DATA_W-KM_COLS){1'b0}}, rows_r[r]};
      end
    end
  end

endmodule

// ===== rtl/keyboard_matrix_port_unit.sv =====
// ----------------------------------------------------------------------------
// keyboard_matrix_port_unit
// Keyboard matrix with key press/release events and a port read channel.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready) takes one transaction per cycle while
//   in_ready is high: in_mode selects press, release or port read;
//   in_host_code names the key for press/release; in_address is the port
//   address for reads. Press/release of a known key sets/clears one matrix
//   bit and gives no result; unknown codes and mode 3 are dropped.
//   A read gives one result transaction on out_valid/out_ready:
//   out_responded is 1 for an even address, and out_read_data is the AND
//   of the active-low rows selected by zeros in address bits 15..8.
//   An odd address returns out_responded = 0 with out_read_data = 0xFF.
// Timing: an accepted read passes the input register, then the result
//   register, where out_valid rises. Throughput: one transaction per cycle
//   while in_ready is high, set by the single pass through the decode and
//   matrix logic.
// Stall: while out_ready is low the result register holds; further
//   press/release transactions still drain, and a following read stops the
//   input register, which then drops in_ready.
// Reset: synchronous, active low; all keys released, both stages empty.
// ----------------------------------------------------------------------------
`include "keyboard_matrix_port_unit_defines.svh"

module keyboard_matrix_port_unit
  import kmp_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [1:0]        in_mode,
  input  logic [CODE_W-1:0] in_host_code,
  input  logic [ADDR_W-1:0] in_address,
  output logic              out_valid,
  input  logic              out_ready,
  output logic              out_responded,
  output logic [DATA_W-1:0] out_read_data
);

  // Input register stage
  logic              s1_valid_r, s1_valid_nxt;
  kmp_mode_t         s1_mode_r;
  logic [CODE_W-1:0] s1_code_r;
  logic [ADDR_W-1:0] s1_addr_r;

  // Result register stage
  logic              out_valid_r, out_valid_nxt;
  logic              out_resp_r;
  logic [DATA_W-1:0] out_data_r;

  logic              s1_is_read;
  logic              s1_adv;
  logic              in_acc;
  kmp_upd_t          upd;
  kmp_upd_t          upd_gated;
  logic [DATA_W-1:0] mtx_data;

  assign s1_is_read = (s1_mode_r == MODE_READ);
  assign s1_adv     = s1_valid_r && (!s1_is_read || !out_valid_r || out_ready);
  assign in_ready   = !s1_valid_r || s1_adv;
  assign in_acc     = in_valid && in_ready;

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (in_acc) begin
      s1_valid_nxt = 1'b1;
    end else if (s1_adv) begin
      s1_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_mode_r <= kmp_mode_t'(in_mode);
      s1_code_r <= in_host_code;
      s1_addr_r <= in_address;
    end
  end

  kmp_key_decode u_decode (
    .mode      (s1_mode_r),
    .host_code (s1_code_r),
    .upd       (upd)
  );

  always_comb begin
    upd_gated    = upd;
    upd_gated.en = upd.en && s1_adv;
  end

  kmp_matrix u_matrix (
    .clk       (clk),
    .rst_n     (rst_n),
    .upd       (upd_gated),
    .row_sel_n (s1_addr_r[ADDR_W-1 -: KM_ROWS]),
    .rd_data   (mtx_data)
  );

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (s1_adv && s1_is_read) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv && s1_is_read) begin
      out_resp_r <= !s1_addr_r[0];
      out_data_r <= s1_addr_r[0] ? BUS_IDLE : mtx_data;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_responded = out_resp_r;
  assign out_read_data = out_data_r;

  `KMP_ASSERT_NOW(a_odd_reads_idle_bus, out_valid_r && !out_resp_r, out_data_r == BUS_IDLE)
  `KMP_ASSERT_NEXT(a_read_lands_in_result, s1_adv && s1_is_read, out_valid_r)
  `KMP_ASSERT_NOW(a_stall_only_on_blocked_read, !in_ready,
                  s1_valid_r && s1_is_read && out_valid_r && !out_ready)
  `KMP_ASSERT_NOW(a_no_update_on_read, upd_gated.en, !s1_is_read && s1_valid_r)

endmodule
